FILE: design/qid_pkg.sv
package qid_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int STACK_DEPTH = 32;

  localparam int SIDE_W      = 11;
  localparam int OUT_COORD_W = 10;
  localparam int SYM_W       = 8;
  localparam int STAR_W      = 20;

  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int GIDX_W  = $clog2(STACK_DEPTH);
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [SYM_W-1:0] CH_STAR = 8'h2A;
  localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE = 8'h39;

  localparam logic [STAR_W-1:0] STAR_MAX = '1;

  // bit positions of a sibling group mask, in push order
  localparam int QB_BR = 0;
  localparam int QB_BL = 1;
  localparam int QB_TR = 2;
  localparam int QB_N  = 3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    QD_BR,
    QD_BL,
    QD_TR
  } quad_t;

  typedef struct packed {
    coord_t r1;
    coord_t c1;
    coord_t r2;
    coord_t c2;
  } region_t;

  typedef struct packed {
    coord_t r1;
    coord_t c1;
    coord_t r2;
    coord_t c2;
    coord_t mr;
    coord_t mc;
  } stk_entry_t;

  typedef struct packed {
    logic             clr;
    logic             push;
    logic             pop;
    stk_entry_t       entry;
    logic [QB_N-1:0]  mask;
  } stk_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    region_t           child;
  } stk_stat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } qid_in_t;

  typedef struct packed {
    logic                   fill_valid;
    logic [OUT_COORD_W-1:0] row_first;
    logic [OUT_COORD_W-1:0] col_first;
    logic [OUT_COORD_W-1:0] row_final;
    logic [OUT_COORD_W-1:0] col_final;
    logic [SYM_W-1:0]       fill_symbol;
    logic [STAR_W-1:0]      star_count;
    logic                   end_of_image;
    logic                   decode_complete;
  } qid_out_t;

  function automatic logic [OUT_COORD_W-1:0] out_coord(coord_t c);
    logic [COORD_W+OUT_COORD_W-1:0] ext;
    ext = {{OUT_COORD_W{1'b0}}, c};
    return ext[OUT_COORD_W-1:0];
  endfunction

endpackage

FILE: design/qid_ram.sv
module qid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/qid_stack.sv
module qid_stack import qid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  logic [FILL_W-1:0] gcount;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] gcount_m1;
  logic [FILL_W-1:0] push_cnt;
  logic [GIDX_W-1:0] top_idx;
  logic [GIDX_W-1:0] push_idx;
  logic [QB_N-1:0]   gmask [STACK_DEPTH];
  logic [QB_N-1:0]   top_mask;
  logic [QB_N-1:0]   top_mask_next;
  quad_t             pop_sel;
  quad_t             child_sel;
  logic              do_push;
  logic              do_pop;
  stk_entry_t        rd_entry;
  coord_t            mr_p1;
  coord_t            mc_p1;

  assign do_push   = cmd.push && !cmd.clr;
  assign do_pop    = cmd.pop && !cmd.clr;
  assign gcount_m1 = gcount - 1'b1;
  assign top_idx   = gcount_m1[GIDX_W-1:0];
  assign push_idx  = gcount[GIDX_W-1:0];
  assign top_mask  = gmask[top_idx];
  assign push_cnt  = FILL_W'(cmd.mask[QB_BR]) + FILL_W'(cmd.mask[QB_BL])
                   + FILL_W'(cmd.mask[QB_TR]);

  always_comb begin
    top_mask_next = top_mask;
    if (top_mask[QB_TR]) begin
      pop_sel = QD_TR;
      top_mask_next[QB_TR] = 1'b0;
    end else if (top_mask[QB_BL]) begin
      pop_sel = QD_BL;
      top_mask_next[QB_BL] = 1'b0;
    end else begin
      pop_sel = QD_BR;
      top_mask_next[QB_BR] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      gcount    <= '0;
      fill      <= '0;
      child_sel <= QD_BR;
    end else if (do_push) begin
      gcount <= gcount + 1'b1;
      fill   <= fill + push_cnt;
    end else if (do_pop) begin
      if (top_mask_next == '0) begin
        gcount <= gcount_m1;
      end
      fill      <= fill - 1'b1;
      child_sel <= pop_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      gmask[push_idx] <= cmd.mask;
    end else if (do_pop) begin
      gmask[top_idx] <= top_mask_next;
    end
  end

  qid_ram #(
    .WIDTH($bits(stk_entry_t)),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(push_idx),
    .wdata(cmd.entry),
    .re   (do_pop),
    .raddr(top_idx),
    .rdata(rd_entry)
  );

  assign mr_p1 = rd_entry.mr + 1'b1;
  assign mc_p1 = rd_entry.mc + 1'b1;

  always_comb begin
    stat.fill = fill;
    case (child_sel)
      QD_TR: begin
        stat.child.r1 = rd_entry.r1;
        stat.child.c1 = mc_p1;
        stat.child.r2 = rd_entry.mr;
        stat.child.c2 = rd_entry.c2;
      end
      QD_BL: begin
        stat.child.r1 = mr_p1;
        stat.child.c1 = rd_entry.c1;
        stat.child.r2 = rd_entry.r2;
        stat.child.c2 = rd_entry.mc;
      end
      default: begin
        stat.child.r1 = mr_p1;
        stat.child.c1 = mc_p1;
        stat.child.r2 = rd_entry.r2;
        stat.child.c2 = rd_entry.c2;
      end
    endcase
  end

endmodule

FILE: design/qid_outbuf.sv
module qid_outbuf import qid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  qid_out_t push_data,
  output logic     space,
  output logic     out_valid,
  input  logic     out_ready,
  output qid_out_t out_data
);

  localparam logic [1:0] OB_FULL = 2'd2;

  qid_out_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       pop;

  assign space     = cnt != OB_FULL;
  assign out_valid = cnt != '0;
  assign out_data  = slots[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

FILE: design/quadtree_image_decoder.sv
// Quadtree image decoder.
// in channel: one beat per character of the compressed stream (symbol, last).
// out channel: one beat per rectangle fill, and one for the character marked
//   last even when it fills nothing; star count and completion ride along.
// cfg channel: one beat writes the image side and restarts the image; send it
//   only while no character is in flight and all results have been taken.
// Throughput: one character per cycle while in_ready is high. The sibling
//   stack sits in a one-port-read memory: a pop issues the read on the
//   accepting edge and the next character works on the registered read
//   data, so pops never stall the input.
// Sibling quadrants of one split are kept as one stack entry with a mask.
// Reset: side 1024, whole image pending, empty stack, star count zero.
// Receiver stall: a two-beat output buffer keeps taking characters until it
//   holds two undelivered results, then in_ready drops until a beat leaves.
module quadtree_image_decoder import qid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qid_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qid_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_data
);

  coord_t            side_m1;
  region_t           cur_reg;
  logic              cur_from_ram;
  logic              region_pending;
  logic              reading_digits;
  logic [STAR_W-1:0] star_counter;

  logic              in_fire;
  logic              cfg_fire;
  region_t           cur;
  logic              single;
  logic              is_digit;
  logic              is_star;
  logic [STAR_W-1:0] star_next;
  logic              do_fill;
  logic              do_split;
  logic              set_digits;
  logic              do_pop;
  logic              done;
  logic [COORD_W:0]  sum_r;
  logic [COORD_W:0]  sum_c;
  coord_t            mid_r;
  coord_t            mid_c;
  logic [QB_N-1:0]   nonempty;
  logic [QB_N-1:0]   push_mask;
  logic [FILL_W-1:0] room;
  logic [FILL_W-1:0] cnt;
  logic [SIDE_W+COORD_W-1:0] cfg_ext;
  logic [SIDE_W+COORD_W-1:0] cfg_m1;
  coord_t            cfg_side_m1;
  stk_cmd_t          stk_cmd;
  stk_stat_t         stk_stat;
  qid_out_t          res;
  logic              res_push;
  logic              space;

  assign in_ready  = space;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign cfg_ext = {{COORD_W{1'b0}}, cfg_data};
  assign cfg_m1  = cfg_ext - 1'b1;
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_side_m1 = '0;
    end else if (cfg_ext > (SIDE_W+COORD_W)'(MAX_SIDE)) begin
      cfg_side_m1 = COORD_W'(MAX_SIDE - 1);
    end else begin
      cfg_side_m1 = cfg_m1[COORD_W-1:0];
    end
  end

  assign cur      = cur_from_ram ? stk_stat.child : cur_reg;
  assign single   = (cur.r1 == cur.r2) && (cur.c1 == cur.c2);
  assign is_digit = (in_data.symbol >= CH_ZERO) && (in_data.symbol <= CH_NINE);
  assign is_star  = in_data.symbol == CH_STAR;
  assign star_next = (is_star && star_counter != STAR_MAX) ? star_counter + 1'b1
                                                            : star_counter;

  assign sum_r = {1'b0, cur.r1} + {1'b0, cur.r2};
  assign sum_c = {1'b0, cur.c1} + {1'b0, cur.c2};
  assign mid_r = sum_r[COORD_W:1];
  assign mid_c = sum_c[COORD_W:1];

  always_comb begin
    nonempty        = '0;
    nonempty[QB_BR] = (cur.r1 != cur.r2) && (cur.c1 != cur.c2);
    nonempty[QB_BL] = cur.r1 != cur.r2;
    nonempty[QB_TR] = cur.c1 != cur.c2;
  end

  assign room = FILL_W'(STACK_DEPTH) - stk_stat.fill;

  always_comb begin
    cnt       = '0;
    push_mask = '0;
    for (int i = 0; i < QB_N; i++) begin
      if (nonempty[i] && cnt < room) begin
        push_mask[i] = 1'b1;
        cnt          = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    do_fill    = 1'b0;
    do_split   = 1'b0;
    set_digits = 1'b0;
    if (region_pending) begin
      if (reading_digits) begin
        do_fill = !is_digit;
      end else if (single) begin
        do_fill = 1'b1;
      end else if (is_digit) begin
        set_digits = 1'b1;
      end else begin
        do_split = 1'b1;
      end
    end
  end

  assign do_pop = do_fill && (stk_stat.fill != '0);
  assign done   = do_fill && (stk_stat.fill == '0);

  assign stk_cmd.clr         = cfg_fire || (in_fire && in_data.last);
  assign stk_cmd.push        = in_fire && do_split && (push_mask != '0);
  assign stk_cmd.pop         = in_fire && do_pop;
  assign stk_cmd.mask        = push_mask;
  assign stk_cmd.entry.r1    = cur.r1;
  assign stk_cmd.entry.c1    = cur.c1;
  assign stk_cmd.entry.r2    = cur.r2;
  assign stk_cmd.entry.c2    = cur.c2;
  assign stk_cmd.entry.mr    = mid_r;
  assign stk_cmd.entry.mc    = mid_c;

  qid_stack u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .stat(stk_stat)
  );

  always_comb begin
    res.fill_valid      = do_fill;
    res.row_first       = do_fill ? out_coord(cur.r1) : '0;
    res.col_first       = do_fill ? out_coord(cur.c1) : '0;
    res.row_final       = do_fill ? out_coord(cur.r2) : '0;
    res.col_final       = do_fill ? out_coord(cur.c2) : '0;
    res.fill_symbol     = do_fill ? in_data.symbol : '0;
    res.star_count      = star_next;
    res.end_of_image    = in_data.last;
    res.decode_complete = !(region_pending && !done);
  end

  assign res_push = in_fire && (do_fill || in_data.last);

  qid_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1        <= COORD_W'(MAX_SIDE - 1);
      cur_reg.r1     <= '0;
      cur_reg.c1     <= '0;
      cur_reg.r2     <= COORD_W'(MAX_SIDE - 1);
      cur_reg.c2     <= COORD_W'(MAX_SIDE - 1);
      cur_from_ram   <= 1'b0;
      region_pending <= 1'b1;
      reading_digits <= 1'b0;
      star_counter   <= '0;
    end else if (cfg_fire) begin
      side_m1        <= cfg_side_m1;
      cur_reg.r1     <= '0;
      cur_reg.c1     <= '0;
      cur_reg.r2     <= cfg_side_m1;
      cur_reg.c2     <= cfg_side_m1;
      cur_from_ram   <= 1'b0;
      region_pending <= 1'b1;
      reading_digits <= 1'b0;
      star_counter   <= '0;
    end else if (in_fire) begin
      if (in_data.last) begin
        cur_reg.r1     <= '0;
        cur_reg.c1     <= '0;
        cur_reg.r2     <= side_m1;
        cur_reg.c2     <= side_m1;
        cur_from_ram   <= 1'b0;
        region_pending <= 1'b1;
        reading_digits <= 1'b0;
        star_counter   <= '0;
      end else begin
        star_counter <= star_next;
        if (set_digits) begin
          reading_digits <= 1'b1;
        end
        if (do_fill) begin
          reading_digits <= 1'b0;
        end
        if (do_pop) begin
          cur_from_ram <= 1'b1;
        end
        if (done) begin
          region_pending <= 1'b0;
          cur_from_ram   <= 1'b0;
        end
        if (do_split) begin
          cur_reg.r1   <= cur.r1;
          cur_reg.c1   <= cur.c1;
          cur_reg.r2   <= mid_r;
          cur_reg.c2   <= mid_c;
          cur_from_ram <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stk_stat.fill <= FILL_W'(STACK_DEPTH))
    else $error("sibling stack fill beyond depth");

  a_ram_pending: assert property (@(posedge clk) disable iff (rst)
    cur_from_ram |-> region_pending)
    else $error("popped region without pending decode");

  a_digits_pending: assert property (@(posedge clk) disable iff (rst)
    reading_digits |-> region_pending)
    else $error("digit run without pending region");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.last) |=> (stk_stat.fill == '0 && region_pending))
    else $error("image state not restarted after last beat");
`endif

endmodule
